// ----- hdl/pngenc_pkg.sv -----
`default_nettype none
package pngenc_pkg;
    localparam int BYTE_W     = 8;
    localparam int DIM_W      = 15;
    localparam int MAX_DIM    = 16384;
    localparam int RAW_W      = 30;
    localparam int BLOCK_MAX  = 65535;
    localparam int ADLER_MOD  = 65521;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam int HDR_LAST   = 42;
    localparam int TAIL_LAST  = 19;
    localparam int BLKH_LAST  = 4;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BODY = 3'b010,
        ST_TAIL = 3'b100
    } state_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/png_stored_rgb_encoder.sv -----
`default_nettype none
// PNG writer for 8-bit RGB images, zlib stored blocks (no compression). Feed the
// color bytes of one image in raster order (R, G, B interleaved); each input word
// releases the file bytes it causes, one output word per cycle while m_tready does
// not stall the output, tlast on the last byte of that input and tuser on the final
// IEND byte. The first word of a file also releases the signature, IHDR, IDAT head
// and zlib header, each row start adds the filter byte, each stored block start adds
// the block header, and the last word of the image adds the trailer; all other words
// release only their own byte, and the next input word is taken in the cycle its
// predecessor's last byte is emitted, so the output byte rate sets the pace. Width
// and height (registers 0 and 1) are sampled when a file starts and are locked until
// IEND; 0 reads as 1 and values above 16384 saturate.
module png_stored_rgb_encoder
    import pngenc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] color_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,   // run_last
    output logic             m_tuser    // [0] file_end
);
    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;

    // sizes derived from configuration, settled during the header
    logic [RAW_W-1:0] raw_reg;
    logic [15:0]      blocks_reg;
    logic [31:0]      idat_reg;

    // stream state
    state_t           state_reg;
    logic             header_sent_reg;
    logic             hdr_active_reg;
    logic [5:0]       hcnt_reg;
    logic             in_blk_reg;
    logic [2:0]       bcnt_reg;
    logic [4:0]       tcnt_reg;
    logic             filt_done_reg;
    logic [15:0]      row_pos_reg;
    logic [RAW_W-1:0] raw_left_reg;
    logic [15:0]      block_left_reg;
    logic [15:0]      adler_lo_reg, adler_hi_reg;
    logic [31:0]      crc_reg;
    logic [7:0]       item_reg;

    // output word register
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg, m_user_reg;

    assign eff_w = eff_dim(width_reg);
    assign eff_h = eff_dim(height_reg);

    // raw = h * (3w + 1), blocks = ceil(raw / 65535), idat = 6 + 5*blocks + raw
    logic [15:0] row_raw;
    logic [30:0] raw_prod;
    logic [30:0] raw_bias;
    logic [14:0] q0;
    logic [16:0] rsum;
    logic [15:0] row_bytes;
    assign row_raw   = 16'({eff_w, 1'b0}) + 16'(eff_w) + 16'd1;
    assign raw_prod  = 31'(eff_h) * 31'(row_raw);
    assign raw_bias  = 31'(raw_reg) + 31'(BLOCK_MAX - 1);
    assign q0        = raw_bias[30:16];
    assign rsum      = 17'(raw_bias[15:0]) + 17'(q0);
    assign row_bytes = 16'({eff_w, 1'b0}) + 16'(eff_w);

    always_ff @(posedge aclk) begin
        raw_reg    <= raw_prod[RAW_W-1:0];
        blocks_reg <= 16'(q0) + ((rsum >= 17'(BLOCK_MAX)) ? 16'd1 : 16'd0);
        idat_reg   <= 32'd6 + 32'({blocks_reg, 2'b00}) + 32'(blocks_reg) + 32'(raw_reg);
    end

    // stored block header fields
    logic [15:0] blk_len;
    logic        blk_final;
    assign blk_final = (raw_left_reg <= RAW_W'(BLOCK_MAX));
    assign blk_len   = blk_final ? raw_left_reg[15:0] : 16'(BLOCK_MAX);

    // byte selection for this cycle
    logic       adv, emit;
    logic [7:0] byte_out;
    logic       crc_en, adl_en, crc_restart, last_byte, fend;
    logic       is_hdr, is_blk, is_filt, is_data;
    logic [2:0] bidx;
    logic [31:0] adler_word;

    assign adv  = !m_valid_reg || m_tready;
    assign emit = (state_reg != ST_IDLE) && adv;
    assign adler_word = {adler_hi_reg, adler_lo_reg};
    assign bidx = in_blk_reg ? bcnt_reg : 3'd0;

    always_comb begin
        is_hdr = 1'b0; is_blk = 1'b0; is_filt = 1'b0; is_data = 1'b0;
        byte_out = 8'd0; crc_en = 1'b0; adl_en = 1'b0; crc_restart = 1'b0;
        last_byte = 1'b0; fend = 1'b0;
        if (state_reg == ST_TAIL) begin
            crc_en = 1'b1;
            case (tcnt_reg)
                5'd0: byte_out = adler_word[31:24];
                5'd1: byte_out = adler_word[23:16];
                5'd2: byte_out = adler_word[15:8];
                5'd3: byte_out = adler_word[7:0];
                5'd4, 5'd16: begin byte_out = ~crc_reg[31:24]; crc_en = 1'b0; end
                5'd5, 5'd17: begin byte_out = ~crc_reg[23:16]; crc_en = 1'b0; end
                5'd6, 5'd18: begin byte_out = ~crc_reg[15:8];  crc_en = 1'b0; end
                5'd7, 5'd19: begin
                    byte_out = ~crc_reg[7:0]; crc_en = 1'b0; crc_restart = 1'b1;
                end
                5'd8, 5'd9, 5'd10, 5'd11: begin byte_out = 8'd0; crc_en = 1'b0; end
                5'd12: byte_out = 8'h49;
                5'd13: byte_out = 8'h45;
                5'd14: byte_out = 8'h4E;
                5'd15: byte_out = 8'h44;
                default: byte_out = 8'd0;
            endcase
            if (tcnt_reg == 5'(TAIL_LAST)) begin
                last_byte = 1'b1;
                fend = 1'b1;
            end
        end else if (hdr_active_reg) begin
            is_hdr = 1'b1;
            case (hcnt_reg)
                6'd0:  byte_out = 8'h89;
                6'd1:  byte_out = 8'h50;
                6'd2:  byte_out = 8'h4E;
                6'd3:  byte_out = 8'h47;
                6'd4:  byte_out = 8'h0D;
                6'd5:  byte_out = 8'h0A;
                6'd6:  byte_out = 8'h1A;
                6'd7:  byte_out = 8'h0A;
                6'd11: byte_out = 8'h0D;
                6'd12: begin byte_out = 8'h49; crc_en = 1'b1; end
                6'd13: begin byte_out = 8'h48; crc_en = 1'b1; end
                6'd14: begin byte_out = 8'h44; crc_en = 1'b1; end
                6'd15: begin byte_out = 8'h52; crc_en = 1'b1; end
                6'd18: begin byte_out = 8'({1'b0, eff_w} >> 8); crc_en = 1'b1; end
                6'd19: begin byte_out = eff_w[7:0]; crc_en = 1'b1; end
                6'd22: begin byte_out = 8'({1'b0, eff_h} >> 8); crc_en = 1'b1; end
                6'd23: begin byte_out = eff_h[7:0]; crc_en = 1'b1; end
                6'd24: begin byte_out = 8'd8; crc_en = 1'b1; end
                6'd25: begin byte_out = 8'd2; crc_en = 1'b1; end
                6'd16, 6'd17, 6'd20, 6'd21, 6'd26, 6'd27, 6'd28: begin
                    byte_out = 8'd0; crc_en = 1'b1;
                end
                6'd29: byte_out = ~crc_reg[31:24];
                6'd30: byte_out = ~crc_reg[23:16];
                6'd31: byte_out = ~crc_reg[15:8];
                6'd32: begin byte_out = ~crc_reg[7:0]; crc_restart = 1'b1; end
                6'd33: byte_out = idat_reg[31:24];
                6'd34: byte_out = idat_reg[23:16];
                6'd35: byte_out = idat_reg[15:8];
                6'd36: byte_out = idat_reg[7:0];
                6'd37: begin byte_out = 8'h49; crc_en = 1'b1; end
                6'd38: begin byte_out = 8'h44; crc_en = 1'b1; end
                6'd39: begin byte_out = 8'h41; crc_en = 1'b1; end
                6'd40: begin byte_out = 8'h54; crc_en = 1'b1; end
                6'd41: begin byte_out = 8'h78; crc_en = 1'b1; end
                6'd42: begin byte_out = 8'h01; crc_en = 1'b1; end
                default: byte_out = 8'd0;
            endcase
        end else if (in_blk_reg || block_left_reg == 16'd0) begin
            is_blk = 1'b1;
            crc_en = 1'b1;
            case (bidx)
                3'd0: byte_out = {7'd0, blk_final};
                3'd1: byte_out = blk_len[7:0];
                3'd2: byte_out = blk_len[15:8];
                3'd3: byte_out = ~blk_len[7:0];
                3'd4: byte_out = ~blk_len[15:8];
                default: byte_out = 8'd0;
            endcase
        end else if (row_pos_reg == 16'd0 && !filt_done_reg) begin
            is_filt = 1'b1;
            crc_en = 1'b1;
            adl_en = 1'b1;
            byte_out = 8'd0;
        end else begin
            is_data = 1'b1;
            crc_en = 1'b1;
            adl_en = 1'b1;
            byte_out = item_reg;
            last_byte = (raw_left_reg != RAW_W'(1));
        end
    end

    // running checksums
    logic [31:0] crc_upd;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_mod, hi_mod;
    assign crc_upd = crc_byte(crc_reg, byte_out);
    assign lo_sum  = 17'(adler_lo_reg) + 17'(byte_out);
    assign lo_mod  = (lo_sum >= 17'(ADLER_MOD)) ? 16'(lo_sum - 17'(ADLER_MOD)) : lo_sum[15:0];
    assign hi_sum  = 17'(adler_hi_reg) + 17'(lo_mod);
    assign hi_mod  = (hi_sum >= 17'(ADLER_MOD)) ? 16'(hi_sum - 17'(ADLER_MOD)) : hi_sum[15:0];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE) || (emit && last_byte);
    assign accept   = s_tvalid && s_tready;

    // configuration port, locked while a file is open
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end else if (cfg_we && !header_sent_reg) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            header_sent_reg <= 1'b0;
            hdr_active_reg  <= 1'b0;
            hcnt_reg        <= '0;
            in_blk_reg      <= 1'b0;
            bcnt_reg        <= '0;
            tcnt_reg        <= '0;
            filt_done_reg   <= 1'b0;
            row_pos_reg     <= '0;
            raw_left_reg    <= '0;
            block_left_reg  <= '0;
            adler_lo_reg    <= 16'd1;
            adler_hi_reg    <= '0;
            crc_reg         <= '1;
        end else begin
            if (emit) begin
                if (crc_restart) begin
                    crc_reg <= '1;
                end else if (crc_en) begin
                    crc_reg <= crc_upd;
                end
                if (adl_en) begin
                    adler_lo_reg <= lo_mod;
                    adler_hi_reg <= hi_mod;
                end
                if (is_hdr) begin
                    hcnt_reg <= hcnt_reg + 6'd1;
                    if (hcnt_reg == 6'(HDR_LAST)) begin
                        hdr_active_reg <= 1'b0;
                        raw_left_reg   <= raw_reg;
                        block_left_reg <= '0;
                    end
                end
                if (is_blk) begin
                    if (bidx == 3'(BLKH_LAST)) begin
                        in_blk_reg     <= 1'b0;
                        block_left_reg <= blk_len;
                    end else begin
                        in_blk_reg <= 1'b1;
                        bcnt_reg   <= bidx + 3'd1;
                    end
                end
                if (is_filt || is_data) begin
                    block_left_reg <= block_left_reg - 16'd1;
                    raw_left_reg   <= raw_left_reg - RAW_W'(1);
                end
                if (is_filt) begin
                    filt_done_reg <= 1'b1;
                end
                if (is_data) begin
                    filt_done_reg <= 1'b0;
                    if (row_pos_reg + 16'd1 >= row_bytes) begin
                        row_pos_reg <= '0;
                    end else begin
                        row_pos_reg <= row_pos_reg + 16'd1;
                    end
                    if (raw_left_reg == RAW_W'(1)) begin
                        state_reg <= ST_TAIL;
                        tcnt_reg  <= '0;
                    end else if (!accept) begin
                        state_reg <= ST_IDLE;
                    end
                end
                if (state_reg == ST_TAIL) begin
                    tcnt_reg <= tcnt_reg + 5'd1;
                    if (tcnt_reg == 5'(TAIL_LAST)) begin
                        // file done: back to reset state, or straight into the next header
                        filt_done_reg   <= 1'b0;
                        row_pos_reg     <= '0;
                        raw_left_reg    <= '0;
                        block_left_reg  <= '0;
                        adler_lo_reg    <= 16'd1;
                        adler_hi_reg    <= '0;
                        if (accept) begin
                            state_reg      <= ST_BODY;
                            hdr_active_reg <= 1'b1;
                            hcnt_reg       <= '0;
                        end else begin
                            state_reg       <= ST_IDLE;
                            header_sent_reg <= 1'b0;
                        end
                    end
                end
            end
            // a word taken while idle starts its run, and a new file when none is open
            if (accept && state_reg == ST_IDLE) begin
                state_reg <= ST_BODY;
                if (!header_sent_reg) begin
                    header_sent_reg <= 1'b1;
                    hdr_active_reg  <= 1'b1;
                    hcnt_reg        <= '0;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= byte_out;
            m_last_reg <= last_byte;
            m_user_reg <= fend;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;
endmodule
`default_nettype wire

// ----- hdl/pngenc_checker.sv -----
`default_nettype none
module pngenc_checker
    import pngenc_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [BYTE_W-1:0] m_tdata,
    input wire logic              m_tlast,
    input wire logic              m_tuser
);
    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // end of file always closes a run
    a_fend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("file end without tlast");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a word is taken under a stalled output only once that output closes its run
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid && !m_tready |-> m_tlast)
        else $error("input taken while a run is still open");
endmodule

bind png_stored_rgb_encoder pngenc_checker u_pngenc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
    import pngenc_pkg::*;

    localparam int STALL_LIMIT = 4000;  // cycles without any word moving
    localparam int SETTLE      = 40;    // longer than the trailer
    localparam int PER_ITEM    = 50;    // most bytes one input can release

    // one word of the png byte stream
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } png_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_WIDTH;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] color_byte
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [7:0]  m_tdata;           // [7:0] out_byte
    wire         m_tlast;           // run_last
    wire         m_tuser;           // [0] file_end

    png_stored_rgb_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // predictor state: its own copy of the registers and running sums
    // ---------------------------------------------------------------
    logic [14:0] width_reg = 15'd1;
    logic [14:0] height_reg = 15'd1;
    logic        file_open;
    logic [31:0] row_pos;
    logic [14:0] rows_done;
    logic [31:0] raw_remaining;
    logic [31:0] block_remaining;
    logic [31:0] adler_a;
    logic [31:0] adler_b;
    logic [31:0] crc_reg;

    png_word_t   step_bytes[$];     // bytes released by the current input
    png_word_t   png_bytes_q[$];    // bytes still due from the block

    int          errors = 0;
    int          idle_mode = 1;     // 0: no idling, 1: normal, 2: light

    function automatic logic [31:0] used_dim(input logic [14:0] v);
        if (v == 15'd0) begin
            return 32'd1;
        end else if (v > 15'd16384) begin
            return 32'd16384;
        end
        return {17'd0, v};
    endfunction

    task automatic clear_png_state();
        file_open       = 1'b0;
        row_pos         = 0;
        rows_done       = 0;
        raw_remaining   = 0;
        block_remaining = 0;
        adler_a         = 1;
        adler_b         = 0;
        crc_reg         = 32'hFFFF_FFFF;
    endtask

    // append one file byte, folding it into the crc and/or adler sums
    task automatic emit(input logic [7:0] b, input bit into_crc, input bit into_adler);
        png_word_t w;
        w.out_byte = b;
        w.run_last = 1'b0;
        w.file_end = 1'b0;
        if (step_bytes.size() < PER_ITEM) begin
            step_bytes.insert(step_bytes.size(), w);
        end
        if (into_crc) begin
            crc_reg = crc_reg ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                crc_reg = (crc_reg >> 1) ^ (crc_reg[0] ? 32'hEDB8_8320 : 32'd0);
            end
        end
        if (into_adler) begin
            adler_a = adler_a + b;
            if (adler_a >= 65521) adler_a = adler_a - 65521;
            adler_b = adler_b + adler_a;
            if (adler_b >= 65521) adler_b = adler_b - 65521;
        end
    endtask

    task automatic emit_be32(input logic [31:0] v, input bit into_crc);
        emit(v[31:24], into_crc, 1'b0);
        emit(v[23:16], into_crc, 1'b0);
        emit(v[15:8], into_crc, 1'b0);
        emit(v[7:0], into_crc, 1'b0);
    endtask

    task automatic emit_crc();
        emit_be32(~crc_reg, 1'b0);
        crc_reg = 32'hFFFF_FFFF;
    endtask

    // raw deflate payload byte, preceded by a stored block header when one starts
    task automatic emit_raw(input logic [7:0] b);
        logic [31:0] len;
        logic [15:0] nlen;
        if (block_remaining == 0) begin
            len  = (raw_remaining > 65535) ? 32'd65535 : raw_remaining;
            nlen = ~len[15:0];
            emit((raw_remaining <= 65535) ? 8'd1 : 8'd0, 1'b1, 1'b0);
            emit(len[7:0], 1'b1, 1'b0);
            emit(len[15:8], 1'b1, 1'b0);
            emit(nlen[7:0], 1'b1, 1'b0);
            emit(nlen[15:8], 1'b1, 1'b0);
            block_remaining = len;
        end
        emit(b, 1'b1, 1'b1);
        if (block_remaining != 0) block_remaining--;
        if (raw_remaining != 0) raw_remaining--;
    endtask

    // signature, ihdr, idat length and type, zlib header
    task automatic open_png_file();
        logic [31:0] w;
        logic [31:0] h;
        longint      raw;
        longint      blocks;
        longint      idat_len;
        w        = used_dim(width_reg);
        h        = used_dim(height_reg);
        raw      = longint'(h) * (3 * longint'(w) + 1);
        blocks   = (raw + 65534) / 65535;
        idat_len = 2 + 5 * blocks + raw + 4;
        clear_png_state();
        emit(8'h89, 0, 0); emit("P", 0, 0); emit("N", 0, 0); emit("G", 0, 0);
        emit(8'h0D, 0, 0); emit(8'h0A, 0, 0); emit(8'h1A, 0, 0); emit(8'h0A, 0, 0);
        emit_be32(32'd13, 0);
        emit("I", 1, 0); emit("H", 1, 0); emit("D", 1, 0); emit("R", 1, 0);
        emit_be32(w, 1);
        emit_be32(h, 1);
        emit(8'd8, 1, 0); emit(8'd2, 1, 0);
        emit(8'd0, 1, 0); emit(8'd0, 1, 0); emit(8'd0, 1, 0);
        emit_crc();
        emit_be32(idat_len[31:0], 0);
        emit("I", 1, 0); emit("D", 1, 0); emit("A", 1, 0); emit("T", 1, 0);
        emit(8'h78, 1, 0); emit(8'h01, 1, 0);
        file_open     = 1'b1;
        raw_remaining = raw[31:0];
    endtask

    // expected png bytes for one accepted color byte
    task automatic predict_png_bytes(input logic [7:0] color);
        logic [31:0] row_len;
        step_bytes.delete();
        if (!file_open) open_png_file();
        row_len = 3 * used_dim(width_reg);
        if (row_pos == 0) emit_raw(8'd0);     // filter type none at row start
        emit_raw(color);
        row_pos++;
        if (row_pos >= row_len) begin
            row_pos   = 0;
            rows_done = rows_done + 15'd1;
        end
        if (raw_remaining == 0) begin
            // adler trailer, idat crc, then the whole iend chunk
            emit_be32({adler_b[15:0], adler_a[15:0]}, 1);
            emit_crc();
            emit_be32(32'd0, 0);
            emit("I", 1, 0); emit("E", 1, 0); emit("N", 1, 0); emit("D", 1, 0);
            emit_crc();
            if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].file_end = 1'b1;
            clear_png_state();
        end
        if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].run_last = 1'b1;
        foreach (step_bytes[i]) png_bytes_q.insert(png_bytes_q.size(), step_bytes[i]);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0) return 0;
        if (idle_mode == 2) return (r < 2) ? $urandom_range(1, 4) : 0;
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // stimulus side
    // ---------------------------------------------------------------
    task automatic send_color(input logic [7:0] color);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= color;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predict_png_bytes(color);
    endtask

    // lower valid and let the block drain; registers only change after this
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (png_bytes_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [14:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (!file_open) begin
            if (idx == REG_WIDTH) width_reg = value;
            else height_reg = value;
        end
    endtask

    task automatic send_image(input logic [14:0] w, input logic [14:0] h);
        int n;
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        n = 3 * used_dim(w) * used_dim(h);
        for (int i = 0; i < n; i++) send_color(8'($urandom));
        wait_drained();
    endtask

    // default 1x1 image straight out of reset, then a second file back to back
    task automatic test_reset_defaults();
        send_color(8'h00);
        send_color(8'hFF);
        send_color(8'hA5);
        send_color(8'h5A);          // next file starts with the same registers
        send_color(8'h01);
        send_color(8'h80);
        wait_drained();
    endtask

    // zero width and height read as one
    task automatic test_zero_dims();
        write_reg(REG_WIDTH, 15'd0);
        write_reg(REG_HEIGHT, 15'd0);
        send_color(8'hFF);
        send_color(8'h00);
        send_color(8'h7F);
        wait_drained();
    endtask

    // 2x2 with rows starting mid-stream, color extremes
    task automatic test_two_rows();
        logic [7:0] pat[12] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE,
                                8'h55, 8'hAA, 8'hFF, 8'hFF, 8'h00, 8'h00};
        write_reg(REG_WIDTH, 15'd2);
        write_reg(REG_HEIGHT, 15'd2);
        foreach (pat[i]) send_color(pat[i]);
        wait_drained();
    endtask

    // many small random images with random idling on both sides
    task automatic test_random_images();
        int sent;
        int w;
        int h;
        sent = 0;
        while (sent < 135) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            idle_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            send_image(15'(w), 15'(h));
            sent += 3 * w * h;
        end
        idle_mode = 1;
    endtask

    // width and height saturate to 16384; the first stored block is a full, non-final one;
    // only the start of this file is sent, it stays open at the end of the run
    task automatic test_saturated_dims();
        idle_mode = 2;
        write_reg(REG_WIDTH, 15'h7FFF);
        write_reg(REG_HEIGHT, 15'h7FFF);
        for (int i = 0; i < 12; i++) send_color(8'($urandom));
        wait_drained();
        idle_mode = 1;
    endtask

    // ---------------------------------------------------------------
    // result side: random back-pressure and the byte checker
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            int g;
            g = pick_gap();
            if (g > 0) begin
                stall_left <= g - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (png_bytes_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: byte %h last %b end %b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                png_word_t exp_w;
                exp_w = png_bytes_q.pop_front();
                if (m_tdata !== exp_w.out_byte) begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, exp_w.out_byte, m_tdata);
                end
                if (m_tlast !== exp_w.run_last) begin
                    errors++;
                    $display("%0t: run_last expected %b actual %b",
                             $time, exp_w.run_last, m_tlast);
                end
                if (m_tuser !== exp_w.file_end) begin
                    errors++;
                    $display("%0t: file_end expected %b actual %b",
                             $time, exp_w.file_end, m_tuser);
                end
            end
        end
    end

    // watchdog: any word moving on either side resets the count
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_png_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_zero_dims();
        test_two_rows();
        test_random_images();
        test_saturated_dims();
        if (png_bytes_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, png_bytes_q.size());
        end
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/pngenc_pkg.sv
hdl/png_stored_rgb_encoder.sv
hdl/pngenc_checker.sv
tb/tb_top.sv
